// File: src/a51_pkg.sv
// ---------------------------------------------------------------------------
// a51_pkg
// Shared types, constants and LFSR step functions for the A5/1 keystream
// generator.
// ---------------------------------------------------------------------------
package a51_pkg;

  localparam int R1_W = 19;
  localparam int R2_W = 22;
  localparam int R3_W = 23;
  localparam int KEY_W = 64;
  localparam int FRAME_W = 22;
  localparam int KEY_CLOCKS = 64;
  localparam int FRAME_CLOCKS = 22;
  localparam int CNT_W = 6;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_SETUP = 2'd1,
    REQ_GEN   = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_LOAD     = 3'd1,
    OP_KEY_MIX  = 3'd2,
    OP_CLOCK    = 3'd3,
    OP_FRAME_MIX = 3'd4,
    OP_GEN      = 3'd5
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   push;     // write a result item into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;   // output register empty or being taken this cycle
  } dp_stat_t;

  function automatic logic [R1_W-1:0] step_r1(input logic [R1_W-1:0] r);
    return {r[R1_W-2:0], r[18] ^ r[17] ^ r[16] ^ r[13]};
  endfunction

  function automatic logic [R2_W-1:0] step_r2(input logic [R2_W-1:0] r);
    return {r[R2_W-2:0], r[21] ^ r[20]};
  endfunction

  function automatic logic [R3_W-1:0] step_r3(input logic [R3_W-1:0] r);
    return {r[R3_W-2:0], r[22] ^ r[21] ^ r[20] ^ r[7]};
  endfunction

endpackage

// File: src/a51_datapath.sv
// ---------------------------------------------------------------------------
// a51_datapath
// LFSR registers, session key, captured frame number and the result
// output register.
// ---------------------------------------------------------------------------
module a51_datapath
  import a51_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               cfg_we,
  input  logic [KEY_W-1:0]   cfg_wdata,
  input  logic [FRAME_W-1:0] frame_in,
  input  logic [R1_W-1:0]    load_r1,
  input  logic [R2_W-1:0]    load_r2,
  input  logic [R3_W-1:0]    load_r3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_keystream_bit,
  output logic               out_majority_bit,
  output logic [2:0]         out_stepped_mask
);

  logic [R1_W-1:0]    r1_r, r1_nxt;
  logic [R2_W-1:0]    r2_r, r2_nxt;
  logic [R3_W-1:0]    r3_r, r3_nxt;
  logic [KEY_W-1:0]   key_r;
  logic [FRAME_W-1:0] frame_r;
  logic               out_valid_r;
  logic               ks_r, maj_r;
  logic [2:0]         mask_r;

  logic       c1, c2, c3, maj, ks;
  logic [2:0] mask;

  assign c1   = r1_r[8];
  assign c2   = r2_r[10];
  assign c3   = r3_r[10];
  assign maj  = (c1 & c2) | (c1 & c3) | (c2 & c3);
  assign ks   = r1_r[R1_W-1] ^ r2_r[R2_W-1] ^ r3_r[R3_W-1];
  assign mask = {c3 == maj, c2 == maj, c1 == maj};

  always_comb begin
    r1_nxt = r1_r;
    r2_nxt = r2_r;
    r3_nxt = r3_r;
    case (cmd.op)
      OP_LOAD: begin
        r1_nxt = load_r1;
        r2_nxt = load_r2;
        r3_nxt = load_r3;
      end
      OP_KEY_MIX: begin
        r1_nxt = r1_r ^ key_r[63:45];
        r2_nxt = r2_r ^ key_r[44:23];
        r3_nxt = r3_r ^ key_r[22:0];
      end
      OP_CLOCK: begin
        r1_nxt = step_r1(r1_r);
        r2_nxt = step_r2(r2_r);
        r3_nxt = step_r3(r3_r);
      end
      OP_FRAME_MIX: begin
        r1_nxt = r1_r ^ frame_r[21:3];
        r2_nxt = r2_r ^ frame_r;
        r3_nxt = r3_r ^ {frame_r, 1'b0};
      end
      OP_GEN: begin
        if (mask[0]) r1_nxt = step_r1(r1_r);
        if (mask[1]) r2_nxt = step_r2(r2_r);
        if (mask[2]) r3_nxt = step_r3(r3_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_r        <= '0;
      r2_r        <= '0;
      r3_r        <= '0;
      key_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      r1_r <= r1_nxt;
      r2_r <= r2_nxt;
      r3_r <= r3_nxt;
      if (cfg_we) key_r <= cfg_wdata;
      if (cmd.push) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_KEY_MIX) frame_r <= frame_in;
    if (cmd.push) begin
      if (cmd.op == OP_GEN) begin
        ks_r   <= ks;
        maj_r  <= maj;
        mask_r <= mask;
      end else begin
        ks_r   <= 1'b0;
        maj_r  <= 1'b0;
        mask_r <= 3'b000;
      end
    end
  end

  assign stat.out_free     = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_keystream_bit = ks_r;
  assign out_majority_bit  = maj_r;
  assign out_stepped_mask  = mask_r;

endmodule

// File: src/a51_ctrl.sv
// ---------------------------------------------------------------------------
// a51_ctrl
// Request sequencer: load and generate issued directly from idle, and the key/frame
// setup sequence with its clock counter.
// ---------------------------------------------------------------------------
module a51_ctrl
  import a51_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_KEY   = 5'b00010,
    S_FMIX  = 5'b00100,
    S_FRAME = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_ready = (state_r == S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NOP;
    cmd.push  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req_t'(in_req_type))
            REQ_LOAD: begin
              cmd.op   = OP_LOAD;
              cmd.push = 1'b1;
            end
            REQ_SETUP: begin
              cmd.op    = OP_KEY_MIX;
              cnt_nxt   = '0;
              state_nxt = S_KEY;
            end
            REQ_GEN: begin
              cmd.op   = OP_GEN;
              cmd.push = 1'b1;
            end
            default: cmd.push = 1'b1;
          endcase
        end
      end
      S_KEY: begin
        cmd.op  = OP_CLOCK;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(KEY_CLOCKS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FMIX;
        end
      end
      S_FMIX: begin
        cmd.op    = OP_FRAME_MIX;
        state_nxt = S_FRAME;
      end
      S_FRAME: begin
        cmd.op  = OP_CLOCK;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRAME_CLOCKS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for room in the output register
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: src/a5_1_keystream_generator.sv
// ---------------------------------------------------------------------------
// a5_1_keystream_generator
// A5/1 keystream generator: three LFSRs (19/22/23 bits) with load, key and
// frame setup, and majority-clocked keystream generation.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request item: load,
//   setup or generate. Output channel (out_valid/out_ready) returns exactly
//   one result item per request, in order. cfg_we/cfg_wdata write the 64-bit
//   session key; write it only while the block is idle.
//   Load and generate act on the LFSRs when accepted; the result appears in the
//   output register the next cycle, and a new item can be accepted every
//   cycle while the receiver keeps up.
//   Setup runs key mix, 64 regular clocks, frame mix and 22 regular clocks
//   on the one LFSR datapath, then pushes the result into the output register
//   once it has room; no new item is accepted until then. The sequence
//   counter in the controller counts the regular clocks.
//   When the receiver stalls, the result holds in the output register and
//   in_ready drops until it is taken.
//   Reset (rst_n low, synchronous) clears the LFSRs, the key and the
//   output valid.
// ---------------------------------------------------------------------------
module a5_1_keystream_generator
  import a51_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [KEY_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [FRAME_W-1:0] in_frame_bits,
  input  logic [R1_W-1:0]    in_load_r1,
  input  logic [R2_W-1:0]    in_load_r2,
  input  logic [R3_W-1:0]    in_load_r3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_keystream_bit,
  output logic               out_majority_bit,
  output logic [2:0]         out_stepped_mask
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  a51_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd)
  );

  a51_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .frame_in          (in_frame_bits),
    .load_r1           (in_load_r1),
    .load_r2           (in_load_r2),
    .load_r3           (in_load_r3),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_keystream_bit (out_keystream_bit),
    .out_majority_bit  (out_majority_bit),
    .out_stepped_mask  (out_stepped_mask)
  );

  // a setup item keeps the input closed while it runs
  a_setup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_SETUP |=> !in_ready)
    else $error("input accepted during setup sequence");

  // generate always shifts at least two registers
  a_gen_mask: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_GEN |=>
      out_valid && $countones(out_stepped_mask) >= 2)
    else $error("generate result with fewer than two registers stepped");

  // load results are all zero, like every non-generate result
  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_LOAD |=>
      out_valid && !out_keystream_bit && !out_majority_bit && out_stepped_mask == 3'b000)
    else $error("load result not zero");

endmodule
